@@ rtl/core/vbi_frame_code_reader_unit_assert.svh @@
// assertion macros shared by the frame code reader modules
`ifndef VBI_FRAME_CODE_READER_UNIT_ASSERT_SVH
`define VBI_FRAME_CODE_READER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VFCR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vfcr check failed");

// next-cycle implication, checked outside reset
`define VFCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vfcr check failed");

`endif

@@ rtl/core/vfcr_pkg.sv @@
// shared constants, window bound tables and item types of the frame code reader
`timescale 1ns / 1ps
`default_nettype none

package vfcr_pkg;

  // line and code geometry
  localparam int unsigned BIT_COUNT        = 24;
  localparam int unsigned FIRST_BIT_OFFSET = 147;
  localparam int unsigned WIN_PITCH        = 630;
  localparam int unsigned WIN_HALF         = 315;

  localparam int unsigned POS_W    = 11;
  localparam int unsigned CNT_W    = $clog2(BIT_COUNT + 1);
  localparam int unsigned IDX_W    = (BIT_COUNT > 1) ? $clog2(BIT_COUNT) : 1;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned SUM_W    = 21;
  localparam int unsigned DEC_W    = 26;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned CODE_W   = 24;
  localparam int unsigned FRAME_W  = 17;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // level conversion, Q8 IRE
  localparam logic signed [LEVEL_W-1:0] LEVEL_SYNC = -16'sd25600;
  localparam logic signed [LEVEL_W:0]   LEVEL_BASE = -17'sd10240;
  localparam logic [31:0]               LEVEL_RND  = 32'd32766;
  localparam logic [17:0]               LEVEL_DIV  = 18'd65533;
  localparam logic [17:0]               LEVEL_DIV2 = 18'd131066;

  // bit decision: 11 * sum < threshold * 256 * 315
  localparam logic signed [DEC_W-1:0] DEC_MUL   = 26'sd11;
  localparam logic signed [DEC_W-1:0] DEC_SCALE = 26'sd80640;

  // configuration
  localparam logic signed [THR_W-1:0] THR_RESET      = 8'sd50;
  localparam logic [PADDR_W-1:0]      ADDR_THRESHOLD = 3'd0;

  // frame code range: top five bits all set, top digit below six
  localparam logic [4:0] CODE_TOP     = 5'h1f;
  localparam logic [2:0] DIGIT4_LIMIT = 3'd6;

  // window bound tables
  typedef logic [POS_W-1:0] win_rom_t [BIT_COUNT];

  function automatic win_rom_t build_win_rom(input int unsigned off);
    win_rom_t rom;
    for (int unsigned k = 0; k < BIT_COUNT; k++) begin
      rom[k] = POS_W'(FIRST_BIT_OFFSET + (WIN_PITCH * k + off) / 11);
    end
    return rom;
  endfunction

  localparam win_rom_t WIN_FIRST = build_win_rom(WIN_HALF);
  localparam win_rom_t WIN_END   = build_win_rom(WIN_PITCH);

  // one sample item after window lookup and level conversion
  typedef struct packed {
    logic                      valid;
    logic                      clear;
    logic                      add;
    logic                      close;
    logic                      last;
    logic signed [LEVEL_W-1:0] level;
  } win_item_t;

endpackage

`default_nettype wire

@@ rtl/core/vfcr_front.sv @@
// sample position tracking, window lookup and level-to-IRE conversion
`timescale 1ns / 1ps
`default_nettype none

module vfcr_front
  import vfcr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                accept_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                line_start_i,
  output win_item_t           item_o
);

  // level to Q8 IRE, exact divide by 65533 via (65536 - 3) remainder fixup
  function automatic logic signed [LEVEL_W-1:0] level_q8(input logic [SAMPLE_W-1:0] lvl);
    logic [31:0]           num;
    logic [15:0]           q0;
    logic [17:0]           rem;
    logic [15:0]           q;
    logic signed [LEVEL_W:0] res;
    num = ({lvl, 15'b0} + {3'b0, lvl, 13'b0}) + LEVEL_RND;
    q0  = num[31:16];
    rem = {2'b0, num[15:0]} + {2'b0, q0} + {1'b0, q0, 1'b0};
    q   = q0 + 16'(rem >= LEVEL_DIV) + 16'(rem >= LEVEL_DIV2);
    res = LEVEL_BASE + $signed({1'b0, q});
    if (lvl == '0) begin
      return LEVEL_SYNC;
    end
    return res[LEVEL_W-1:0];
  endfunction

  logic [POS_W-1:0] pos_q, pos_d, pos;
  logic [CNT_W-1:0] bidx_q, bidx_d, bidx;
  logic [IDX_W-1:0] ridx;
  logic [POS_W-1:0] win_first, win_end;
  logic             active, in_win, close, last;
  win_item_t        item_q, item_d;

  // window lookup for the current position
  always_comb begin
    pos       = line_start_i ? '0 : pos_q;
    bidx      = line_start_i ? '0 : bidx_q;
    active    = bidx < CNT_W'(BIT_COUNT);
    ridx      = active ? bidx[IDX_W-1:0] : '0;
    win_first = WIN_FIRST[ridx];
    win_end   = WIN_END[ridx];
    in_win    = active && (pos >= win_first) && (pos < win_end);
    close     = in_win && ((pos + POS_W'(1)) == win_end);
    last      = close && (bidx == CNT_W'(BIT_COUNT - 1));
  end

  // position and bit counter advance
  always_comb begin
    pos_d  = pos_q;
    bidx_d = bidx_q;
    if (accept_i) begin
      pos_d  = (pos == POS_MAX) ? pos : pos + POS_W'(1);
      bidx_d = close ? bidx + CNT_W'(1) : bidx;
    end
  end

  // item for the accumulate stage
  always_comb begin
    item_d.valid = accept_i;
    item_d.clear = line_start_i;
    item_d.add   = in_win;
    item_d.close = close;
    item_d.last  = last;
    item_d.level = level_q8(sample_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      bidx_q <= '0;
      item_q <= '0;
    end else begin
      pos_q  <= pos_d;
      bidx_q <= bidx_d;
      if (en_i) begin
        item_q <= item_d;
      end
    end
  end

  assign item_o = item_q;

`include "vbi_frame_code_reader_unit_assert.svh"

  `VFCR_ASSERT_SAME(a_bidx_range, 1'b1, bidx_q <= CNT_W'(BIT_COUNT))
  `VFCR_ASSERT_NEXT(a_line_restart, accept_i && line_start_i, (bidx_q == '0) && (pos_q == POS_W'(1)))

endmodule

`default_nettype wire

@@ rtl/core/vfcr_accum.sv @@
// window sum accumulation, bit decision and code shift register
`timescale 1ns / 1ps
`default_nettype none

module vfcr_accum
  import vfcr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  win_item_t                item_i,
  input  logic signed [THR_W-1:0]  threshold_i,
  output logic                     code_valid_o,
  output logic [CODE_W-1:0]        code_o
);

  logic signed [SUM_W-1:0] sum_q, sum_d, sum_base, sum_next;
  logic [CODE_W-1:0]       code_q, code_d, code_base, code_next;
  logic signed [DEC_W-1:0] lhs, rhs;
  logic                    bit_one;
  logic                    cv_q;
  logic [CODE_W-1:0]       cc_q;

  // add the level and decide the bit at window close
  always_comb begin
    sum_base  = item_i.clear ? '0 : sum_q;
    code_base = item_i.clear ? '0 : code_q;
    sum_next  = sum_base + SUM_W'(item_i.level);
    lhs       = DEC_W'(sum_next) * DEC_MUL;
    rhs       = DEC_W'(threshold_i) * DEC_SCALE;
    bit_one   = lhs < rhs;
    code_next = {code_base[CODE_W-2:0], bit_one};
  end

  // state update per item
  always_comb begin
    sum_d  = sum_q;
    code_d = code_q;
    if (en_i && item_i.valid) begin
      if (item_i.add) begin
        sum_d = item_i.close ? '0 : sum_next;
      end else begin
        sum_d = sum_base;
      end
      code_d = item_i.close ? code_next : code_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      code_q <= '0;
      cv_q   <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      code_q <= code_d;
      if (en_i) begin
        cv_q <= item_i.valid && item_i.close && item_i.last;
      end
    end
  end

  // finished code, payload only
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q <= code_next;
    end
  end

  assign code_valid_o = cv_q;
  assign code_o       = cc_q;

endmodule

`default_nettype wire

@@ rtl/core/vfcr_result.sv @@
// frame code check, BCD to binary frame number and output register
`timescale 1ns / 1ps
`default_nettype none

module vfcr_result
  import vfcr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                code_valid_i,
  input  logic [CODE_W-1:0]   code_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [CODE_W-1:0]   code_o,
  output logic                frame_valid_o,
  output logic [FRAME_W-1:0]  frame_number_o
);

  logic               fv;
  logic [FRAME_W-1:0] num;
  logic               load;
  logic               out_valid_q, out_valid_d;
  logic [CODE_W-1:0]  code_q;
  logic               fv_q;
  logic [FRAME_W-1:0] num_q;

  // code above 0xF80000 and below 0xFE0000: low 19 bits are five BCD digits, else number is zero
  always_comb begin
    fv  = (code_i[23:19] == CODE_TOP) && (code_i[18:16] < DIGIT4_LIMIT)
          && (code_i[18:0] != '0);
    num = FRAME_W'(code_i[3:0])
        + FRAME_W'(code_i[7:4])   * FRAME_W'(10)
        + FRAME_W'(code_i[11:8])  * FRAME_W'(100)
        + FRAME_W'(code_i[15:12]) * FRAME_W'(1000)
        + FRAME_W'(code_i[18:16]) * FRAME_W'(10000);
    if (!fv) begin
      num = '0;
    end
  end

  // output register handshake
  assign load = en_i && code_valid_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q <= code_i;
      fv_q   <= fv;
      num_q  <= num;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_o         = code_q;
  assign frame_valid_o  = fv_q;
  assign frame_number_o = num_q;

`include "vbi_frame_code_reader_unit_assert.svh"

  `VFCR_ASSERT_SAME(a_no_overwrite, load, !out_valid_q || out_ready_i)
  `VFCR_ASSERT_SAME(a_frame_zero, out_valid_o && !frame_valid_o, frame_number_o == '0)
  `VFCR_ASSERT_SAME(a_frame_top, out_valid_o && frame_valid_o, code_o[23:19] == CODE_TOP)

endmodule

`default_nettype wire

@@ rtl/core/vbi_frame_code_reader_unit.sv @@
// top level of the frame code reader: register port, stall control, stages
//
//   channel  | direction | signals                                   | item
//   ---------+-----------+-------------------------------------------+------------------
//   in       | sink      | in_valid_i, in_ready_o                    | sample, line_start
//   out      | source    | out_valid_o, out_ready_i                  | code, frame fields
//   config   | apb       | psel, penable, pwrite, paddr, pwdata ...  | bit threshold
//
// one sample item per cycle while the input is not stalled; a sample's result is registered in turn
// in the front register, the accumulate register and the output register
// reset clears position, bit count, window sum, code and the threshold (to 50 IRE)
// the input stalls only while a finished code waits behind an output item not yet taken
// at most one result per line, so stalls last only as long as the sink holds ready low
`timescale 1ns / 1ps
`default_nettype none

module vbi_frame_code_reader_unit
  import vfcr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // sample channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                line_start_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CODE_W-1:0]   code_o,
  output logic                frame_valid_o,
  output logic [FRAME_W-1:0]  frame_number_o,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic                    en;
  logic                    accept;
  logic                    code_valid;
  logic [CODE_W-1:0]       code;
  win_item_t               item;
  logic signed [THR_W-1:0] thr_q;
  logic                    thr_hit;

  // threshold register
  assign thr_hit = (paddr == ADDR_THRESHOLD);
  assign pready  = 1'b1;
  assign prdata  = thr_hit ? PDATA_W'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && thr_hit) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  // stall everything while a finished code cannot enter the output register
  assign en         = !(code_valid && out_valid_o && !out_ready_i);
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  vfcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .accept_i     (accept),
    .sample_i     (sample_i),
    .line_start_i (line_start_i),
    .item_o       (item)
  );

  vfcr_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .item_i       (item),
    .threshold_i  (thr_q),
    .code_valid_o (code_valid),
    .code_o       (code)
  );

  vfcr_result u_result (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .code_valid_i   (code_valid),
    .code_i         (code),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .code_o         (code_o),
    .frame_valid_o  (frame_valid_o),
    .frame_number_o (frame_number_o)
  );

`include "vbi_frame_code_reader_unit_assert.svh"

  `VFCR_ASSERT_SAME(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i && code_valid)

endmodule

`default_nettype wire
